[design/signed_decimal_record_codec_defines.svh]
// Assertion macros used by the codec back part.
`ifndef SIGNED_DECIMAL_RECORD_CODEC_DEFINES_SVH
`define SIGNED_DECIMAL_RECORD_CODEC_DEFINES_SVH

// Checks that an implication holds at every clock edge outside reset.
`define SDRC_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Checks that a condition leads to a consequence in the next cycle.
`define SDRC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[design/sdrc_pkg.sv]
package sdrc_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 4;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CNT_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENCODE = 2'd0,
        FN_DECODE = 2'd1,
        FN_END    = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_DIGIT     = 4'd0,
        ST_VALUE     = 4'd1,
        ST_END       = 4'd2,
        ST_BAD_CDIG  = 4'd3,
        ST_BAD_SIGN  = 4'd4,
        ST_BAD_COUNT = 4'd5,
        ST_BAD_DIGIT = 4'd6,
        ST_RANGE     = 4'd7,
        ST_TRUNC     = 4'd8
    } t_status;

    // Item handed from the front part to the back part.
    typedef struct packed {
        t_func              func;
        logic [VALUE_W-1:0] value;
        logic [7:0]         digit;
    } t_item;

    // One result beat.
    typedef struct packed {
        t_status            status;
        logic [3:0]         digit;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

endpackage

[design/sdrc_front.sv]
// Accepts input beats, drops unused function codes and queues the rest.
module sdrc_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  sdrc_pkg::t_item       i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output sdrc_pkg::t_item       o_item
);
    import sdrc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign w_push  = i_valid && o_ready && (i_item.func != FN_NONE);
    assign o_valid = (r_cnt != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

[design/sdrc_back.sv]
`include "signed_decimal_record_codec_defines.svh"
// Executes queued items: encode steps through convert and emit; decode is done in idle.
module sdrc_back #(
    parameter int unsigned MAX_DIGITS = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sdrc_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output sdrc_pkg::t_result o_res
);
    import sdrc_pkg::*;

    typedef enum logic [2:0] {
        PH_TENS  = 3'd0,
        PH_UNITS = 3'd1,
        PH_SIGN  = 3'd2,
        PH_DATA  = 3'd3,
        PH_SKIP  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CONV = 2'd1,
        S_EMIT = 2'd2
    } t_state;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    t_state            r_state;
    t_phase            r_phase;
    logic [3:0]        r_tens;
    logic [CNT_W-1:0]  r_count, r_taken;
    logic              r_neg;
    logic [63:0]       r_mag;
    // encoder
    logic [63:0]       r_emag;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_p;
    logic [CNT_W-1:0]  r_k;
    logic              r_eneg;
    logic              r_ov;
    t_result           r_res;

    logic              w_accept, w_slot;
    logic [63:0]       w_lim, w_abs;
    logic [7:0]        w_cnt;
    logic [67:0]       w_prod;
    logic [3:0]        w_d;
    logic [CNT_W-1:0]  w_ndig;
    logic [63:0]       w_pw, w_sub;
    logic [3:0]        w_dig;

    function automatic logic [63:0] pow10(input logic [CNT_W-1:0] p);
        logic [63:0] v;
        case (p)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            5'd17:   v = 64'd100000000000000000;
            5'd18:   v = 64'd1000000000000000000;
            5'd19:   v = 64'd10000000000000000000;
            default: v = 64'd0;
        endcase
        return v;
    endfunction

    // Output register slot is free when empty or being drained.
    assign w_slot   = !r_ov || i_ready;
    assign o_ready  = (r_state == S_IDLE) && w_slot;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_ov;
    assign o_res    = r_res;

    // Number of decimal digits of the magnitude, from parallel compares with powers of ten.
    always_comb begin
        w_ndig = CNT_W'(1);
        for (int k = 1; k < 20; k++) begin
            if (r_emag >= pow10(CNT_W'(k))) begin
                w_ndig = CNT_W'(k + 1);
            end
        end
    end

    // The remainder is below ten times the current power, so the digit is the
    // largest multiple of that power that still fits.
    always_comb begin
        w_pw  = pow10(r_p);
        w_dig = 4'd0;
        w_sub = 64'd0;
        for (int j = 1; j < 10; j++) begin
            if (r_emag >= w_pw * 64'(j)) begin
                w_dig = 4'(j);
                w_sub = w_pw * 64'(j);
            end
        end
    end

    assign w_abs  = i_item.value[63] ? (64'd0 - i_item.value) : i_item.value;
    assign w_cnt  = {4'd0, r_tens} * 8'd10 + i_item.digit;
    assign w_d    = i_item.digit[3:0];
    assign w_prod = {4'd0, r_mag} * 68'd10 + {64'd0, w_d};
    assign w_lim  = r_neg ? I64_MAX + 64'd1 : I64_MAX;

    always_ff @(posedge i_clk) begin
        logic n_ov;
        n_ov = r_ov && !i_ready;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_TENS;
            r_tens  <= '0;
            r_count <= '0;
            r_taken <= '0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_ov    <= 1'b0;
            r_n     <= '0;
            r_p     <= '0;
            r_k     <= '0;
            r_eneg  <= 1'b0;
            r_emag  <= '0;
            r_res   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_item.func)
                            FN_ENCODE: begin
                                r_emag  <= w_abs;
                                r_eneg  <= i_item.value[63];
                                r_state <= S_CONV;
                            end
                            FN_DECODE: begin
                                case (r_phase)
                                    PH_TENS: begin
                                        if (i_item.digit > 8'd9) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_BAD_CDIG, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else begin
                                            r_tens  <= i_item.digit[3:0];
                                            r_phase <= PH_UNITS;
                                        end
                                    end
                                    PH_UNITS: begin
                                        if (i_item.digit > 8'd9) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_BAD_CDIG, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else begin
                                            r_count <= (w_cnt >= 8'd1 &&
                                                        w_cnt <= 8'(MAX_DIGITS))
                                                       ? w_cnt[CNT_W-1:0] : '0;
                                            r_phase <= PH_SIGN;
                                        end
                                    end
                                    PH_SIGN: begin
                                        if (i_item.digit > 8'd1) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_BAD_SIGN, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else if (r_count == '0) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_BAD_COUNT, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else begin
                                            r_neg   <= i_item.digit[0];
                                            r_mag   <= '0;
                                            r_taken <= '0;
                                            r_phase <= PH_DATA;
                                        end
                                    end
                                    PH_DATA: begin
                                        if (i_item.digit > 8'd9) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_BAD_DIGIT, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else if (w_prod[67:64] != 4'd0) begin
                                            r_phase <= PH_SKIP;
                                            r_res   <= '{ST_RANGE, 4'd0, 64'd0, 1'b1};
                                            n_ov     = 1'b1;
                                        end else begin
                                            r_mag   <= w_prod[63:0];
                                            r_taken <= r_taken + 1'b1;
                                            if (r_taken + 1'b1 >= r_count) begin
                                                n_ov = 1'b1;
                                                if (w_prod[63:0] > w_lim) begin
                                                    r_phase <= PH_SKIP;
                                                    r_res   <= '{ST_RANGE, 4'd0,
                                                                 64'd0, 1'b1};
                                                end else begin
                                                    r_phase <= PH_TENS;
                                                    r_res   <= '{ST_VALUE, 4'd0,
                                                        r_neg ? 64'd0 - w_prod[63:0]
                                                              : w_prod[63:0], 1'b1};
                                                end
                                            end
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            FN_END: begin
                                r_res <= '{(r_phase == PH_UNITS || r_phase == PH_SIGN ||
                                            r_phase == PH_DATA) ? ST_TRUNC : ST_END,
                                           4'd0, 64'd0, 1'b1};
                                n_ov     = 1'b1;
                                r_phase <= PH_TENS;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_n     <= w_ndig;
                    r_p     <= w_ndig - 1'b1;
                    r_k     <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot) begin
                        n_ov = 1'b1;
                        r_k <= r_k + 1'b1;
                        if (r_k == 5'd0) begin
                            r_res <= '{ST_DIGIT, (r_n >= 5'd10) ? 4'd1 : 4'd0, 64'd0, 1'b0};
                        end else if (r_k == 5'd1) begin
                            r_res <= '{ST_DIGIT, (r_n >= 5'd10) ? 4'(r_n - 5'd10)
                                                                : 4'(r_n), 64'd0, 1'b0};
                        end else if (r_k == 5'd2) begin
                            r_res <= '{ST_DIGIT, {3'd0, r_eneg}, 64'd0, 1'b0};
                        end else begin
                            // Magnitude digits, most significant first.
                            r_res  <= '{ST_DIGIT, w_dig, 64'd0, r_p == '0};
                            r_emag <= r_emag - w_sub;
                            r_p    <= r_p - 1'b1;
                            if (r_p == '0) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            r_ov <= n_ov;
        end
    end

    `SDRC_ASSERT_IMP(a_digit, i_clk, i_rst_n, r_ov && r_res.status == ST_DIGIT,
        r_res.digit <= 4'd9, "encoded digit above nine")
    `SDRC_ASSERT_NEXT(a_stall, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_res),
        "result lost under stall")
    `SDRC_ASSERT_IMP(a_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready,
        "item taken during encode")
    `SDRC_ASSERT_IMP(a_cnt, i_clk, i_rst_n, r_state == S_EMIT, r_n >= 5'd1 && r_n <= 5'd19,
        "encode digit count out of range")
    `SDRC_ASSERT_IMP(a_pos, i_clk, i_rst_n, r_state == S_EMIT, r_p < r_n,
        "encode digit position out of range")
endmodule

[design/signed_decimal_record_codec.sv]
// A decode or end beat is taken from the queue by the back part when that part is idle and
// its output slot is free, and its result is registered there; decode beats sustain one per
// cycle while the receiver takes every result. An encode item holds the back part while it
// is taken, while its digits are counted and while its output beats leave: two count digits,
// its sign and its n = 1..19 magnitude digits, each when the output slot is free.
// Synchronous active-low reset returns the parser to the count tens digit and empties all queues.
module signed_decimal_record_codec #(
    parameter int unsigned MAX_DIGITS = 19
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // in_value[63:0], in_digit[71:64]
    input  logic [1:0]   s_axis_tuser,   // func[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // out_digit[3:0], out_value[67:4], zeros
    output logic [3:0]   m_axis_tuser,   // status[3:0]
    output logic         m_axis_tlast
);
    import sdrc_pkg::*;

    t_item   w_in, w_q;
    logic    w_qv, w_qr;
    t_result w_res;

    assign w_in.func  = t_func'(s_axis_tuser);
    assign w_in.value = s_axis_tdata[63:0];
    assign w_in.digit = s_axis_tdata[71:64];

    sdrc_front #(.DEPTH(2)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    sdrc_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {4'd0, w_res.value, w_res.digit};
    assign m_axis_tuser = w_res.status;
    assign m_axis_tlast = w_res.last;
endmodule

[test/codec_checker.sv]
module codec_checker #(
    parameter int unsigned MAX_DIGITS = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic [3:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_values
);
    import sdrc_pkg::*;

    typedef enum logic [2:0] {
        PH_TENS, PH_UNITS, PH_SIGN, PH_DATA, PH_SKIP
    } t_phase;

    t_result     expected_beats[$];
    t_phase      phase;
    logic [3:0]  tens;
    logic [4:0]  want_count;
    logic        neg;
    logic [63:0] mag;
    logic [4:0]  taken;

    function automatic t_result mk(t_status st, logic [3:0] d, logic [63:0] v, logic l);
        t_result r;
        r.status = st;
        r.digit  = d;
        r.value  = v;
        r.last   = l;
        return r;
    endfunction

    task automatic push_error(t_status st);
        phase = PH_SKIP;
        expected_beats.push_back(mk(st, 4'd0, 64'd0, 1'b1));
    endtask

    task automatic predict_encode(logic [63:0] v);
        logic [63:0] m;
        logic [3:0]  digs[20];
        int          n;
        m = v[63] ? (64'd0 - v) : v;
        n = 0;
        do begin
            digs[n] = 4'(m % 64'd10);
            m = m / 64'd10;
            n++;
        end while (m != 0);
        expected_beats.push_back(mk(ST_DIGIT, 4'(n / 10), 64'd0, 1'b0));
        expected_beats.push_back(mk(ST_DIGIT, 4'(n % 10), 64'd0, 1'b0));
        expected_beats.push_back(mk(ST_DIGIT, {3'd0, v[63]}, 64'd0, 1'b0));
        for (int i = n; i > 0; i--)
            expected_beats.push_back(mk(ST_DIGIT, digs[i-1], 64'd0, i == 1));
    endtask

    task automatic predict_digit(logic [7:0] d);
        int unsigned cnt;
        logic [63:0] lim;
        case (phase)
            PH_TENS: begin
                if (d > 9) push_error(ST_BAD_CDIG);
                else begin
                    tens = d[3:0];
                    phase = PH_UNITS;
                end
            end
            PH_UNITS: begin
                if (d > 9) push_error(ST_BAD_CDIG);
                else begin
                    cnt = tens * 10 + d;
                    want_count = (cnt >= 1 && cnt <= MAX_DIGITS) ? 5'(cnt) : 5'd0;
                    phase = PH_SIGN;
                end
            end
            PH_SIGN: begin
                if (d > 1) push_error(ST_BAD_SIGN);
                else if (want_count == 0) push_error(ST_BAD_COUNT);
                else begin
                    neg = d[0];
                    mag = 64'd0;
                    taken = 5'd0;
                    phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (d > 9) push_error(ST_BAD_DIGIT);
                else if (mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) push_error(ST_RANGE);
                else begin
                    mag = mag * 64'd10 + d;
                    taken = taken + 5'd1;
                    if (taken >= want_count) begin
                        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                        if (mag > lim) push_error(ST_RANGE);
                        else begin
                            phase = PH_TENS;
                            expected_beats.push_back(mk(ST_VALUE, 4'd0,
                                neg ? (64'd0 - mag) : mag, 1'b1));
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got, exp_beat;
        if (!i_rst_n) begin
            phase = PH_TENS;
            tens = 0; want_count = 0; neg = 0; mag = 0; taken = 0;
            expected_beats.delete();
            o_errors = 0;
            o_results = 0;
            o_values = 0;
        end else begin
            // Compare the output first: a beat never leaves in its own input cycle.
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.digit  = m_axis_tdata[3:0];
                got.value  = m_axis_tdata[67:4];
                got.last   = m_axis_tlast;
                o_results++;
                if (got.status == ST_VALUE) o_values++;
                if (expected_beats.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected beat %h user %h last %b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (got !== exp_beat) begin
                        o_errors++;
                        $display("%0t: mismatch expected st %0d dig %0d val %0d last %b",
                                 $time, exp_beat.status, exp_beat.digit,
                                 $signed(exp_beat.value), exp_beat.last);
                        $display("%0t:            actual st %0d dig %0d val %0d last %b",
                                 $time, got.status, got.digit, $signed(got.value), got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (t_func'(s_axis_tuser))
                    FN_ENCODE: predict_encode(s_axis_tdata[63:0]);
                    FN_DECODE: predict_digit(s_axis_tdata[71:64]);
                    FN_END: begin
                        expected_beats.push_back(mk(
                            (phase >= PH_UNITS && phase <= PH_DATA) ? ST_TRUNC : ST_END,
                            4'd0, 64'd0, 1'b1));
                        phase = PH_TENS;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

[test/tb.sv]
module tb;
    import sdrc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // in_value[63:0], in_digit[71:64]
    logic [1:0]  s_axis_tuser = '0;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // out_digit[3:0], out_value[67:4], zeros
    logic [3:0]  m_axis_tuser;        // status[3:0]
    logic        m_axis_tlast;

    int errors, pending, results, values;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_off = 0;
    int quiet_cycles = 0;
    int items_sent = 0;

    always #6 i_clk = ~i_clk;

    signed_decimal_record_codec dut (.*);

    codec_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .o_errors(errors), .o_pending(pending), .o_results(results), .o_values(values)
    );

    // Receiver: random stalls, or a long hold-off while the pressure test runs.
    always @(posedge i_clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Valid stays high from one beat to the next unless the sender idles; the caller
    // drops it after the last beat of a stretch.
    task automatic send(t_func f, logic [63:0] v, logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {d, v};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Feeds one record as digits; count, sign and data are taken as given.
    task automatic send_record(logic [7:0] t, logic [7:0] u, logic [7:0] s,
                               logic [63:0] mag, int n);
        logic [7:0] digs[20];
        logic [63:0] m;
        m = mag;
        for (int i = 0; i < n; i++) begin
            digs[i] = 8'(m % 10);
            m = m / 10;
        end
        send(FN_DECODE, 64'd0, t);
        send(FN_DECODE, 64'd0, u);
        send(FN_DECODE, 64'd0, s);
        for (int i = n - 1; i >= 0; i--) send(FN_DECODE, 64'd0, digs[i]);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        // Spread the magnitudes over all digit lengths.
        return $signed(v) >>> $urandom_range(63);
    endfunction

    task automatic random_phase(int count);
        int k;
        logic [63:0] v;
        int n;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1: send(FN_ENCODE, rand_value(), 8'($urandom()));
                2, 3, 4, 5: begin
                    n = $urandom_range(1, 19);
                    v = {$urandom(), $urandom()};
                    if (n < 19) v = v % (64'd1 << (3 * n));
                    send_record(8'(n / 10), 8'(n % 10), 8'($urandom_range(1)), v, n);
                    k += n + 2;
                end
                6: send(FN_END, {$urandom(), $urandom()}, 8'($urandom()));
                7: send(FN_DECODE, {$urandom(), $urandom()}, 8'($urandom()));
                8: send(FN_DECODE, 64'd0, 8'($urandom_range(10)));
                default: send(t_func'($urandom_range(3)), 64'd0, 8'($urandom_range(2)));
            endcase
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int wait_cycles;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: encode extremes, decode edges, each error kind, end cases.
        send(FN_ENCODE, 64'h8000_0000_0000_0000, 8'hFF);
        send(FN_ENCODE, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
        send(FN_ENCODE, 64'd0, 8'h00);
        send(FN_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
        send_record(8'd1, 8'd9, 8'd1, 64'd9223372036854775808, 19);  // minimum accepted
        send_record(8'd1, 8'd9, 8'd0, 64'd9223372036854775808, 19);  // one above maximum
        send_record(8'd1, 8'd9, 8'd0, 64'd9999999999999999999, 19);  // out of range
        send_record(8'd0, 8'd1, 8'd0, 64'd0, 1);
        send(FN_DECODE, 64'd0, 8'd10);                      // bad count digit
        send(FN_DECODE, 64'd0, 8'd3);                        // skipped
        send(FN_END, 64'd0, 8'd0);
        send(FN_DECODE, 64'd0, 8'd2);
        send(FN_DECODE, 64'd0, 8'hFF);                       // bad count digit (units)
        send(FN_END, 64'd0, 8'd0);
        send_record(8'd0, 8'd5, 8'd2, 64'd0, 0);             // bad sign
        send(FN_END, 64'd0, 8'd0);
        send_record(8'd2, 8'd0, 8'd0, 64'd0, 0);             // bad count
        send(FN_END, 64'd0, 8'd0);
        send_record(8'd0, 8'd0, 8'd1, 64'd0, 0);             // zero count
        send(FN_END, 64'd0, 8'd0);
        send_record(8'd0, 8'd3, 8'd1, 64'd12, 2);
        send(FN_DECODE, 64'd0, 8'd11);                       // bad digit
        send(FN_END, 64'd0, 8'd0);
        send(FN_DECODE, 64'd0, 8'd0);
        send(FN_END, 64'd0, 8'd0);                           // truncated
        send(FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);       // ignored
        send(FN_END, 64'd0, 8'd0);                           // end, nothing open

        // Pressure: receiver holds off while encodes keep coming.
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (12) send(FN_ENCODE, rand_value(), 8'd0);
        join

        send_idle_pct = 22; recv_idle_pct = 86;
        random_phase(100);
        send_idle_pct = 86; recv_idle_pct = 22;
        random_phase(100);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(100);

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        $display("Sent %0d items; %0d result beats checked, %0d decoded values.",
                 items_sent, results, values);
        $display("Covered encode extremes, every decode error, truncation and back-pressure.");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sdrc_pkg.sv
design/sdrc_front.sv
design/sdrc_back.sv
design/signed_decimal_record_codec.sv
test/codec_checker.sv
test/tb.sv
